// ----- rtl/countdown_timer_bank_with_holdoff_macros.svh -----
// Assertion macros used by the checker file.
`ifndef COUNTDOWN_TIMER_BANK_WITH_HOLDOFF_MACROS_SVH
`define COUNTDOWN_TIMER_BANK_WITH_HOLDOFF_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CTBH_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CTBH_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds through reset.
`define CTBH_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/ctbh_pkg.sv -----
`default_nettype none

package ctbh_pkg;

    localparam int DUR_W     = 16;
    localparam int CNT_OUT_W = 4;
    localparam int M_DATA_W  = 16;

    localparam logic FUNC_ADD  = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    typedef struct packed {
        logic add;
        logic tick;
    } ctbh_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/countdown_timer_bank_with_holdoff.sv -----
// The result word for an accepted input word is registered and shown in the next cycle.
// Throughput: one word per cycle while the result is taken; every timer steps in parallel.
// s_tready drops only while a result word is held and m_tready is low.
// Reset (aresetn low, synchronous): no timers running, holdoff 0, dead_time 0,
// no result pending.
`default_nettype none

module countdown_timer_bank_with_holdoff #(
    parameter int NUM_TIMERS = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] duration
    input  wire logic [0:0]  s_tuser,   // [0] func
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [0] accepted, [4:1] expired_count,
                                        // [8:5] active_count, [15:9] zero
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data   // dead_time
);
    import ctbh_pkg::*;

    localparam int CNT_W = $clog2(NUM_TIMERS + 1);

    logic [DUR_W-1:0]    dead_time_reg;
    logic [DUR_W-1:0]    holdoff_reg, holdoff_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                s_fire;
    logic                is_add;
    logic                add_ok;
    ctbh_cmd_t           cmd;
    logic [CNT_W-1:0]    expired_cnt;
    logic [CNT_OUT_W-1:0] exp_out;

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign is_add   = (s_tuser[0] == FUNC_ADD);
    assign add_ok   = is_add && (cnt_reg != CNT_W'(NUM_TIMERS)) && (holdoff_reg == '0);
    assign cmd.add  = s_fire && add_ok;
    assign cmd.tick = s_fire && (s_tuser[0] == FUNC_TICK);

    ctbh_bank #(
        .NUM_TIMERS (NUM_TIMERS),
        .CNT_W      (CNT_W)
    ) u_bank (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .duration    (s_tdata),
        .expired_cnt (expired_cnt)
    );

    always_comb begin
        cnt_next     = cnt_reg;
        holdoff_next = holdoff_reg;
        exp_out      = '0;
        if (cmd.add) begin
            cnt_next     = cnt_reg + CNT_W'(1);
            holdoff_next = dead_time_reg;
        end else if (cmd.tick) begin
            cnt_next = cnt_reg - expired_cnt;
            exp_out  = CNT_OUT_W'(expired_cnt);
            if (holdoff_reg != '0) begin
                holdoff_next = holdoff_reg - DUR_W'(1);
            end
        end
        m_tdata_next = {7'd0, CNT_OUT_W'(cnt_next), exp_out, cmd.add};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dead_time_reg <= '0;
            holdoff_reg   <= '0;
            cnt_reg       <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                dead_time_reg <= cfg_data;
            end
            holdoff_reg <= holdoff_next;
            cnt_reg     <= cnt_next;
            if (s_fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ctbh_bank.sv -----
`default_nettype none

module ctbh_bank #(
    parameter int NUM_TIMERS = 8,
    parameter int CNT_W      = $clog2(NUM_TIMERS + 1)
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire ctbh_pkg::ctbh_cmd_t      cmd,
    input  wire logic [ctbh_pkg::DUR_W-1:0] duration,
    output logic [CNT_W-1:0]              expired_cnt
);
    import ctbh_pkg::*;

    logic [NUM_TIMERS-1:0] live_reg, live_next;
    logic [DUR_W-1:0]      val_reg  [NUM_TIMERS];
    logic [DUR_W-1:0]      val_next [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] expire;
    logic [NUM_TIMERS-1:0] free_slot;
    logic [NUM_TIMERS-1:0] add_slot;

    // lowest free slot, one-hot
    assign free_slot = ~live_reg;
    assign add_slot  = free_slot & (~free_slot + NUM_TIMERS'(1));

    always_comb begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
            expire[i] = live_reg[i] && (val_reg[i] <= DUR_W'(1));
        end
    end

    always_comb begin
        expired_cnt = '0;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            expired_cnt = expired_cnt + CNT_W'(expire[i]);
        end
    end

    always_comb begin
        live_next = live_reg;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            val_next[i] = val_reg[i];
            if (cmd.tick) begin
                live_next[i] = live_reg[i] && !expire[i];
                val_next[i]  = val_reg[i] - DUR_W'(1);
            end else if (cmd.add && add_slot[i]) begin
                live_next[i] = 1'b1;
                val_next[i]  = duration;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg <= '0;
        end else begin
            live_reg <= live_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
            val_reg[i] <= val_next[i];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ctbh_checker.sv -----
`default_nettype none

`include "countdown_timer_bank_with_holdoff_macros.svh"

module ctbh_checker #(
    parameter int NUM_TIMERS = 8
) (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata
);

    `CTBH_ASSERT_NXT(a_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata), "result word changed while stalled")

    `CTBH_ASSERT_NXT_ALWAYS(a_rst_empty, aclk, !aresetn, !m_tvalid,
        "result word present after reset")

    `CTBH_ASSERT_IMP(a_add_no_expire, aclk, aresetn, m_tvalid && m_tdata[0],
        m_tdata[4:1] == 4'd0 && (NUM_TIMERS > 15 || m_tdata[8:5] != 4'd0),
        "accepted add reports expiry or empty bank")

    `CTBH_ASSERT_NXT(a_fill, aclk, aresetn, s_tvalid && s_tready,
        m_tvalid, "accepted word gave no result")

endmodule

bind countdown_timer_bank_with_holdoff ctbh_checker #(
    .NUM_TIMERS (NUM_TIMERS)
) u_ctbh_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
